// File: hw/rtl/lcc_pkg.sv
// Types and constants shared by the LBA/CHS converter modules.
`default_nettype none
package lcc_pkg;

    localparam int LBA_W     = 48;
    localparam int CYL_IN_W  = 32;
    localparam int SPT_W     = 6;
    localparam int HPC_W     = 8;
    localparam int PER_CYL_W = SPT_W + HPC_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SPT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HPC   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

    localparam logic CMD_LBA = 1'b0;
    localparam logic CMD_CHS = 1'b1;

    localparam logic [SPT_W-1:0] SPT_RESET   = 6'd63;
    localparam logic [HPC_W-1:0] HPC_RESET   = 8'd255;
    localparam logic [LBA_W-1:0] LIMIT_RESET = 48'd16450560;

    localparam logic [9:0] SAT_CYL    = 10'd1023;
    localparam logic [7:0] SAT_HEAD   = 8'd254;
    localparam logic [5:0] SAT_SECTOR = 6'd63;

    typedef struct packed {
        logic                cmd;
        logic [LBA_W-1:0]    lba_in;
        logic [CYL_IN_W-1:0] cylinder_in;
        logic [7:0]          head_in;
        logic [5:0]          sector_in;
    } t_req;

    typedef struct packed {
        logic [LBA_W-1:0] lba_out;
        logic [LBA_W-1:0] cylinder_out;
        logic [7:0]       head_out;
        logic [5:0]       sector_out;
        logic [1:0]       mbr_cyl_high;
        logic [7:0]       mbr_cyl_low;
        logic [7:0]       mbr_head;
        logic [5:0]       mbr_sector;
        logic             saturated;
    } t_rsp;

endpackage
`default_nettype wire

// File: hw/rtl/lcc_div_cell.sv
// One restoring-division cell: retires one quotient bit per request.
`default_nettype none
module lcc_div_cell #(
    parameter int W  = 8,
    parameter int DW = 6,
    parameter int PW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [W-1:0]  i_dq,
    input  wire logic [DW-1:0] i_divisor,
    input  wire logic [PW-1:0] i_side,
    output logic               o_valid,
    output logic [DW-1:0]      o_rem,
    output logic [W-1:0]       o_dq,
    output logic [PW-1:0]      o_side
);

    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] n_rem;
    logic [W-1:0]  n_dq;

    always_comb begin
        trial = {i_rem, i_dq[W-1]};
        ge    = trial >= {1'b0, i_divisor};
        n_rem = ge ? DW'(trial - {1'b0, i_divisor}) : trial[DW-1:0];
        n_dq  = {i_dq[W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rem  <= n_rem;
        o_dq   <= n_dq;
        o_side <= i_side;
    end

endmodule
`default_nettype wire

// File: hw/rtl/lcc_div_chain.sv
// Row of division cells: W-bit dividend in, registered quotient and remainder out.
`default_nettype none
module lcc_div_chain #(
    parameter int W  = 8,
    parameter int DW = 6,
    parameter int PW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [W-1:0]  i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    input  wire logic [PW-1:0] i_side,
    output logic               o_valid,
    output logic [W-1:0]       o_quot,
    output logic [DW-1:0]      o_rem,
    output logic [PW-1:0]      o_side
);

    logic          v_link [W+1];
    logic [DW-1:0] rem_link [W+1];
    logic [W-1:0]  dq_link [W+1];
    logic [PW-1:0] side_link [W+1];

    assign v_link[0]    = i_valid;
    assign rem_link[0]  = '0;
    assign dq_link[0]   = i_dividend;
    assign side_link[0] = i_side;

    for (genvar g = 0; g < W; g++) begin : g_cell
        lcc_div_cell #(.W(W), .DW(DW), .PW(PW)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (v_link[g]),
            .i_rem     (rem_link[g]),
            .i_dq      (dq_link[g]),
            .i_divisor (i_divisor),
            .i_side    (side_link[g]),
            .o_valid   (v_link[g+1]),
            .o_rem     (rem_link[g+1]),
            .o_dq      (dq_link[g+1]),
            .o_side    (side_link[g+1])
        );
    end

    assign o_valid = v_link[W];
    assign o_quot  = dq_link[W];
    assign o_rem   = rem_link[W];
    assign o_side  = side_link[W];

endmodule
`default_nettype wire

// File: hw/rtl/lba_chs_converter_unit.sv
// Top level: LBA/CHS address converter with MBR packing.
// Takes one request per clock (busy stays low) and returns each result on a one-cycle
// o_done strobe, in request order. The pipeline is four stages forming the LBA, one
// range-check stage, a row of LBA_BITS division cells for the cylinder, 14 cells for
// head and sector, and an output register. The receiver cannot stall; results must be
// taken when strobed. Geometry registers are read live by the pipeline, so write them
// only when no request is in flight.
`default_nettype none
module lba_chs_converter_unit
    import lcc_pkg::*;
#(
    parameter int LBA_BITS = 48
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_req                 i_req,
    output logic                      o_done,
    output t_rsp                      o_rsp,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [LBA_W-1:0]     i_cfg_data
);

    localparam int LW   = LBA_BITS;
    localparam int SUMW = (LW > LBA_W) ? LW : LBA_W;
    localparam int CW   = SUMW;
    localparam int P1W  = CYL_IN_W + HPC_W;
    localparam int P2W  = P1W + 1;
    localparam int P3W  = P2W + SPT_W;
    localparam int S1W  = LW + 1;
    localparam int S2W  = LW + 1 + LW;

    logic [SPT_W-1:0]     r_spt;
    logic [HPC_W-1:0]     r_hpc;
    logic [LBA_W-1:0]     r_limit;
    logic [SPT_W-1:0]     spt_eff;
    logic [HPC_W-1:0]     hpc_eff;
    logic [PER_CYL_W-1:0] r_per_cyl;

    assign busy    = 1'b0;
    assign spt_eff = (r_spt == '0) ? SPT_W'(1) : r_spt;
    assign hpc_eff = (r_hpc == '0) ? HPC_W'(1) : r_hpc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt   <= SPT_RESET;
            r_hpc   <= HPC_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SPT:   r_spt   <= i_cfg_data[SPT_W-1:0];
                REG_HPC:   r_hpc   <= i_cfg_data[HPC_W-1:0];
                REG_LIMIT: r_limit <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_per_cyl <= PER_CYL_W'(spt_eff) * PER_CYL_W'(hpc_eff);
    end

    // LBA forming stages
    logic             r_a_v, r_b_v, r_c_v, r_d_v, r_e_v;
    logic             r_a_cmd, r_b_cmd, r_c_cmd;
    logic [LBA_W-1:0] r_a_lba, r_b_lba, r_c_lba;
    logic [5:0]       r_a_sec, r_b_sec, r_c_sec;
    logic [7:0]       r_a_head;
    logic [P1W-1:0]   r_a_prod;
    logic [P2W-1:0]   r_b_t;
    logic [P3W-1:0]   r_c_p;
    logic [LW-1:0]    r_d_lba, r_e_lba;
    logic             r_e_sat;
    logic [LW-1:0]    n_d_lba;
    logic [SUMW-1:0]  chs_sum;

    always_comb begin
        chs_sum = SUMW'(r_c_p) + SUMW'(r_c_sec) - SUMW'(1);
        n_d_lba = (r_c_cmd == CMD_CHS) ? chs_sum[LW-1:0] : LW'(SUMW'(r_c_lba));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else begin
            r_a_v <= start && !busy;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_cmd  <= i_req.cmd;
        r_a_lba  <= i_req.lba_in;
        r_a_sec  <= i_req.sector_in;
        r_a_head <= i_req.head_in;
        r_a_prod <= P1W'(i_req.cylinder_in) * P1W'(hpc_eff);
        r_b_cmd  <= r_a_cmd;
        r_b_lba  <= r_a_lba;
        r_b_sec  <= r_a_sec;
        r_b_t    <= P2W'(r_a_prod) + P2W'(r_a_head);
        r_c_cmd  <= r_b_cmd;
        r_c_lba  <= r_b_lba;
        r_c_sec  <= r_b_sec;
        r_c_p    <= P3W'(r_b_t) * P3W'(spt_eff);
        r_d_lba  <= n_d_lba;
        r_e_lba  <= r_d_lba;
        r_e_sat  <= CW'(r_d_lba) >= CW'(r_limit);
    end

    // cylinder = lba / per_cyl
    logic                 c1_v;
    logic [LW-1:0]        c1_quot;
    logic [PER_CYL_W-1:0] c1_rem;
    logic [S1W-1:0]       c1_side;

    lcc_div_chain #(.W(LW), .DW(PER_CYL_W), .PW(S1W)) u_cyl_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_e_v),
        .i_dividend (r_e_lba),
        .i_divisor  (r_per_cyl),
        .i_side     ({r_e_lba, r_e_sat}),
        .o_valid    (c1_v),
        .o_quot     (c1_quot),
        .o_rem      (c1_rem),
        .o_side     (c1_side)
    );

    // head = rem / spt, sector - 1 = rem % spt
    logic                 c2_v;
    logic [PER_CYL_W-1:0] c2_quot;
    logic [SPT_W-1:0]     c2_rem;
    logic [S2W-1:0]       c2_side;

    lcc_div_chain #(.W(PER_CYL_W), .DW(SPT_W), .PW(S2W)) u_hs_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (c1_v),
        .i_dividend (c1_rem),
        .i_divisor  (spt_eff),
        .i_side     ({c1_side, c1_quot}),
        .o_valid    (c2_v),
        .o_quot     (c2_quot),
        .o_rem      (c2_rem),
        .o_side     (c2_side)
    );

    logic [LW-1:0] f_lba, f_cyl;
    logic          f_sat;
    logic [7:0]    f_head;
    logic [5:0]    f_sector;
    t_rsp          n_rsp;

    always_comb begin
        f_cyl    = c2_side[LW-1:0];
        f_sat    = c2_side[LW];
        f_lba    = c2_side[S2W-1:LW+1];
        f_head   = c2_quot[7:0];
        f_sector = c2_rem + 6'd1;
        n_rsp.lba_out      = LBA_W'(SUMW'(f_lba));
        n_rsp.cylinder_out = LBA_W'(SUMW'(f_cyl));
        n_rsp.head_out     = f_head;
        n_rsp.sector_out   = f_sector;
        n_rsp.saturated    = f_sat;
        if (f_sat) begin
            n_rsp.mbr_cyl_high = SAT_CYL[9:8];
            n_rsp.mbr_cyl_low  = SAT_CYL[7:0];
            n_rsp.mbr_head     = SAT_HEAD;
            n_rsp.mbr_sector   = SAT_SECTOR;
        end else begin
            n_rsp.mbr_cyl_high = f_cyl[9:8];
            n_rsp.mbr_cyl_low  = f_cyl[7:0];
            n_rsp.mbr_head     = f_head;
            n_rsp.mbr_sector   = f_sector;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= c2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rsp <= n_rsp;
    end

endmodule
`default_nettype wire

// File: hw/rtl/lcc_checker.sv
// Port-level checks for the LBA/CHS converter, bound to the top level.
`default_nettype none
module lcc_checker
    import lcc_pkg::*;
#(
    parameter int LBA_BITS = 48
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_done,
    input wire t_rsp o_rsp
);

    localparam int LAT = LBA_BITS + 20;
    localparam int CNT_W = $clog2(LAT + 1);

    logic [CNT_W-1:0] r_age;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age <= '0;
        end else if (r_age != CNT_W'(LAT)) begin
            r_age <= r_age + CNT_W'(1);
        end
    end

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy asserted");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_age == CNT_W'(LAT)) |-> (o_done == $past(start && !busy, LAT)))
        else $error("result strobe does not match request latency");

    a_sat_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.saturated) |->
        (o_rsp.mbr_cyl_high == SAT_CYL[9:8] && o_rsp.mbr_cyl_low == SAT_CYL[7:0]
         && o_rsp.mbr_head == SAT_HEAD && o_rsp.mbr_sector == SAT_SECTOR))
        else $error("saturated MBR form wrong");

    a_mbr_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_rsp.saturated) |->
        (o_rsp.mbr_head == o_rsp.head_out && o_rsp.mbr_sector == o_rsp.sector_out
         && o_rsp.mbr_cyl_low == o_rsp.cylinder_out[7:0]))
        else $error("MBR form does not follow CHS result");

    a_sector_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.sector_out != 6'd0))
        else $error("sector zero");

endmodule

bind lba_chs_converter_unit lcc_checker #(.LBA_BITS(LBA_BITS)) u_lcc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for the LBA/CHS converter: directed and random requests checked against a predictor.
`default_nettype none
module tb;
    import lcc_pkg::*;

    localparam int LAT = 48 + 20;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_req                 i_req = '0;
    logic                 o_done;
    t_rsp                 o_rsp;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [LBA_W-1:0]     i_cfg_data = '0;

    logic [SPT_W-1:0] geo_spt = SPT_RESET;
    logic [HPC_W-1:0] geo_hpc = HPC_RESET;
    logic [LBA_W-1:0] geo_limit = LIMIT_RESET;

    t_rsp pending_rsp[$];
    int   errors = 0;
    int   gap_left = 0;

    lba_chs_converter_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_done(o_done), .o_rsp(o_rsp),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_rsp convert(t_req r);
        t_rsp        p;
        logic [63:0] spt, hpc, per_cyl, lba, cyl, rem, hd, sec;
        spt = (geo_spt == 0) ? 64'd1 : 64'(geo_spt);
        hpc = (geo_hpc == 0) ? 64'd1 : 64'(geo_hpc);
        per_cyl = spt * hpc;
        if (r.cmd == CMD_CHS)
            lba = ((64'(r.cylinder_in) * hpc + 64'(r.head_in)) * spt
                   + 64'(r.sector_in) - 64'd1) & 64'hFFFF_FFFF_FFFF;
        else
            lba = 64'(r.lba_in);
        cyl = lba / per_cyl;
        rem = lba % per_cyl;
        hd  = rem / spt;
        sec = rem % spt + 1;
        p.lba_out      = lba[47:0];
        p.cylinder_out = cyl[47:0];
        p.head_out     = hd[7:0];
        p.sector_out   = sec[5:0];
        if (lba[47:0] >= geo_limit) begin
            p.mbr_cyl_high = SAT_CYL[9:8];
            p.mbr_cyl_low  = SAT_CYL[7:0];
            p.mbr_head     = SAT_HEAD;
            p.mbr_sector   = SAT_SECTOR;
            p.saturated    = 1'b1;
        end else begin
            p.mbr_cyl_high = cyl[9:8];
            p.mbr_cyl_low  = cyl[7:0];
            p.mbr_head     = hd[7:0];
            p.mbr_sector   = sec[5:0];
            p.saturated    = 1'b0;
        end
        return p;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, o_rsp);
                errors++;
            end else begin
                t_rsp e;
                e = pending_rsp.pop_front();
                if (o_rsp !== e) begin
                    $display("%0t result mismatch: expected %h, actual %h", $time, e, o_rsp);
                    errors++;
                end
            end
        end
    end

    task automatic send_request(t_req r);
        if (gap_left == 0 && $urandom_range(0, 7) == 0)
            gap_left = $urandom_range(1, 12);
        while (gap_left > 0) begin
            @(posedge i_clk);
            start <= 1'b0;
            gap_left--;
        end
        @(posedge i_clk);
        while (busy) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        pending_rsp.push_back(convert(r));
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start <= 1'b0;
    endtask

    // sends without a trailing idle cycle so bursts run back to back
    task automatic send_burst(t_req r);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start <= 1'b1;
        i_req <= r;
        pending_rsp.push_back(convert(r));
    endtask

    task automatic drain();
        @(posedge i_clk);
        start <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_geometry(logic [SPT_W-1:0] spt, logic [HPC_W-1:0] hpc,
                                  logic [LBA_W-1:0] lim);
        drain();
        i_cfg_we <= 1'b1; i_cfg_idx <= REG_SPT; i_cfg_data <= LBA_W'(spt);
        @(posedge i_clk);
        i_cfg_idx <= REG_HPC; i_cfg_data <= LBA_W'(hpc);
        @(posedge i_clk);
        i_cfg_idx <= REG_LIMIT; i_cfg_data <= lim;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        geo_spt = spt; geo_hpc = hpc; geo_limit = lim;
    endtask

    function automatic t_req lba_req(logic [LBA_W-1:0] a);
        t_req r;
        r = '0;
        r.cmd = CMD_LBA;
        r.lba_in = a;
        r.cylinder_in = $urandom; r.head_in = 8'($urandom); r.sector_in = 6'($urandom);
        return r;
    endfunction

    function automatic t_req chs_req(logic [31:0] c, logic [7:0] h, logic [5:0] s);
        t_req r;
        r.cmd = CMD_CHS;
        r.lba_in = LBA_W'({$urandom, $urandom});
        r.cylinder_in = c; r.head_in = h; r.sector_in = s;
        return r;
    endfunction

    function automatic t_req rand_req();
        logic [LBA_W-1:0] a;
        case ($urandom_range(0, 3))
            0: a = LBA_W'({$urandom, $urandom});
            1: a = LBA_W'($urandom_range(0, 20000000));
            2: a = geo_limit + LBA_W'($urandom_range(0, 4)) - LBA_W'(2);
            default: a = LBA_W'($urandom);
        endcase
        if ($urandom_range(0, 1))
            return lba_req(a);
        if ($urandom_range(0, 7) == 0)
            return chs_req($urandom, 8'($urandom), 6'($urandom));
        return chs_req($urandom_range(0, 1100), 8'($urandom_range(0, 254)),
                       6'($urandom_range(1, 63)));
    endfunction

    task automatic test_directed();
        send_request(lba_req('0));
        send_request(lba_req('1));
        send_request(lba_req(LIMIT_RESET - 1));
        send_request(lba_req(LIMIT_RESET));
        send_request(chs_req(0, 0, 1));
        send_request(chs_req(1023, 254, 63));
        send_request(chs_req('1, 8'hFF, 6'h3F));
        send_request(chs_req(0, 0, 0));
        send_request(chs_req(5, 255, 0));
        send_request(chs_req(2000, 10, 5));
    endtask

    task automatic test_geometry_extremes();
        write_geometry(6'd0, 8'd0, '0);
        send_request(lba_req(48'd12345));
        send_request(chs_req(7, 3, 0));
        write_geometry(6'd1, 8'd1, '1);
        send_request(lba_req('1));
        send_request(lba_req(48'd1500));
        send_request(chs_req('1, 8'hFF, 6'h3F));
        write_geometry(6'd63, 8'd255, '1);
        send_request(chs_req(3000, 100, 1));
        send_request(lba_req('1 - 1));
    endtask

    task automatic test_random(int n);
        t_req r;
        for (int i = 0; i < n; i++) begin
            r = rand_req();
            if ($urandom_range(0, 3) == 0) send_request(r);
            else send_burst(r);
        end
    endtask

    task automatic test_random_geometries();
        write_geometry(6'd63, 8'd255, LIMIT_RESET);
        test_random(400);
        drain();
        test_random(100);
        write_geometry(SPT_W'($urandom_range(1, 63)), HPC_W'($urandom_range(1, 255)),
                       LBA_W'($urandom_range(0, 30000000)));
        test_random(400);
        write_geometry(SPT_W'($urandom), HPC_W'($urandom), LBA_W'({$urandom, $urandom}));
        test_random(300);
        write_geometry(6'd17, 8'd16, 48'd1024 * 16 * 17);
        test_random(400);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_geometry_extremes();
        test_random_geometries();
        drain();
        if (errors == 0 && pending_rsp.size() == 0)
            $display("[lba_chs_converter_unit] OK");
        else
            $display("[lba_chs_converter_unit] ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("[lba_chs_converter_unit] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
hw/rtl/lcc_pkg.sv
hw/rtl/lcc_div_cell.sv
hw/rtl/lcc_div_chain.sv
hw/rtl/lba_chs_converter_unit.sv
hw/rtl/lcc_checker.sv
tb/sv/tb.sv
